/* hw/rtl/lobm_pkg.sv */
// Types and constants shared by the order book matcher and its checker.
// Depends on nothing.
package lobm_pkg;

    localparam int ID_W    = 32;
    localparam int PRICE_W = 16;
    localparam int QTY_W   = 24;
    localparam int STAMP_W = 32;

    typedef enum logic [2:0] {
        ST_TRADE  = 3'd0,
        ST_FILLED = 3'd1,
        ST_RESTED = 3'd2,
        ST_FULL   = 3'd3,
        ST_ZERO   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FILLED,
        S_REST
    } t_state;

    typedef struct packed {
        logic               side;
        logic [ID_W-1:0]    order_id;
        logic [PRICE_W-1:0] limit_price;
        logic [QTY_W-1:0]   order_quantity;
    } t_order;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    buy_order_id;
        logic [ID_W-1:0]    sell_order_id;
        logic [PRICE_W-1:0] trade_price;
        logic [QTY_W-1:0]   trade_quantity;
        logic [QTY_W-1:0]   remaining_quantity;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [STAMP_W-1:0] arrival;
    } t_entry;

endpackage

/* hw/rtl/lobm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/limit_order_book_matcher.sv */
// Price-time priority order book matcher. Each fill costs one scan of the
// opposite side through the book RAM.
// A zero-quantity order is answered from idle without raising busy; otherwise
// busy is high until the final result of the order.
// Results are flagged by o_strobe and cannot be stalled.
// Synchronous active-low reset empties both sides and clears the arrival count.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int SIDE_DEPTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_order  i_order,
    output logic    o_strobe,
    output t_result o_result
);
    localparam int IDX_W = $clog2(SIDE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int RAM_D = 2 * (2 ** IDX_W);
    localparam int ENT_W = $bits(t_entry);

    t_state                   r_state, n_state;
    t_order                   r_order, n_order;
    logic [QTY_W-1:0]         r_rem, n_rem;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_cmp_v, n_cmp_v;
    logic [IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic                     r_found, n_found;
    logic [IDX_W-1:0]         r_best_idx, n_best_idx;
    t_entry                   r_best, n_best;
    logic [CNT_W-1:0]         r_ntrade, n_ntrade;
    logic [STAMP_W-1:0]       r_arrival, n_arrival;
    logic [1:0][SIDE_DEPTH-1:0] r_valid, n_valid;
    logic                     r_strobe, n_strobe;
    t_result                  r_result, n_result;

    logic                     ram_we;
    logic [IDX_W:0]           ram_waddr, ram_raddr;
    t_entry                   ram_wdata;
    logic [ENT_W-1:0]         ram_rdata;
    t_entry                   rd_ent;

    logic                     buying, opp, accept;
    logic [QTY_W-1:0]         fill_qty, rem_after, rest_qty;
    logic                     crosses, better;
    logic                     free_found;
    logic [IDX_W-1:0]         free_idx;

    lobm_ram #(.WIDTH(ENT_W), .DEPTH(RAM_D)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = t_entry'(ram_rdata);
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign buying = !r_order.side;
    assign opp    = !r_order.side;

    assign fill_qty  = (r_rem < r_best.qty) ? r_rem : r_best.qty;
    assign rem_after = r_rem - fill_qty;
    assign rest_qty  = r_best.qty - fill_qty;

    // Candidate from the RAM against the best found so far in this scan.
    always_comb begin
        crosses = buying ? (rd_ent.price <= r_order.limit_price)
                         : (rd_ent.price >= r_order.limit_price);
        if (!r_found) begin
            better = 1'b1;
        end else if (rd_ent.price != r_best.price) begin
            better = buying ? (rd_ent.price < r_best.price)
                            : (rd_ent.price > r_best.price);
        end else begin
            better = (r_arrival - rd_ent.arrival) > (r_arrival - r_best.arrival);
        end
    end

    // Lowest free slot on the incoming order's own side.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SIDE_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[r_order.side][k]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_order.order_quantity != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cmp_v && (r_cmp_idx == IDX_W'(SIDE_DEPTH - 1))) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!r_found) begin
                    n_state = S_REST;
                end else if (rem_after == '0) begin
                    n_state = S_FILLED;
                end else if ((r_ntrade + 1'b1) == CNT_W'(SIDE_DEPTH)) begin
                    n_state = S_REST;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FILLED: n_state = S_IDLE;
            S_REST:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_order    = r_order;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_cmp_v    = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_ntrade   = r_ntrade;
        n_arrival  = r_arrival;
        n_valid    = r_valid;
        n_strobe   = 1'b0;
        n_result   = r_result;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = r_best;
        ram_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_order  = i_order;
                    n_rem    = i_order.order_quantity;
                    n_cnt    = '0;
                    n_found  = 1'b0;
                    n_ntrade = '0;
                    if (i_order.order_quantity == '0) begin
                        n_strobe = 1'b1;
                        n_result = '{status: ST_ZERO, buy_order_id: i_order.order_id,
                                     sell_order_id: '0, trade_price: '0,
                                     trade_quantity: '0, remaining_quantity: '0,
                                     last: 1'b1};
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt < CNT_W'(SIDE_DEPTH)) begin
                    ram_raddr = {opp, r_cnt[IDX_W-1:0]};
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_cnt[IDX_W-1:0];
                    n_cnt     = r_cnt + 1'b1;
                end
                if (r_cmp_v && r_valid[opp][r_cmp_idx] && crosses && better) begin
                    n_found    = 1'b1;
                    n_best_idx = r_cmp_idx;
                    n_best     = rd_ent;
                end
            end
            S_DECIDE: begin
                n_cnt   = '0;
                n_found = 1'b0;
                if (r_found) begin
                    n_rem    = rem_after;
                    n_ntrade = r_ntrade + 1'b1;
                    if (rest_qty == '0) begin
                        n_valid[opp][r_best_idx] = 1'b0;
                    end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = {opp, r_best_idx};
                        ram_wdata.qty = rest_qty;
                    end
                    n_strobe = 1'b1;
                    n_result = '{status: ST_TRADE,
                                 buy_order_id:  buying ? r_order.order_id : r_best.id,
                                 sell_order_id: buying ? r_best.id : r_order.order_id,
                                 trade_price: r_best.price, trade_quantity: fill_qty,
                                 remaining_quantity: rem_after, last: 1'b0};
                end
            end
            S_FILLED: begin
                n_strobe = 1'b1;
                n_result = '{status: ST_FILLED, buy_order_id: r_order.order_id,
                             sell_order_id: '0, trade_price: '0, trade_quantity: '0,
                             remaining_quantity: '0, last: 1'b1};
            end
            S_REST: begin
                n_strobe = 1'b1;
                n_result = '{status: ST_FULL, buy_order_id: r_order.order_id,
                             sell_order_id: '0, trade_price: '0, trade_quantity: '0,
                             remaining_quantity: r_rem, last: 1'b1};
                if (free_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_order.side, free_idx};
                    ram_wdata = '{id: r_order.order_id, price: r_order.limit_price,
                                  qty: r_rem, arrival: r_arrival};
                    n_valid[r_order.side][free_idx] = 1'b1;
                    n_arrival       = r_arrival + 1'b1;
                    n_result.status = ST_RESTED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_v   <= 1'b0;
            r_arrival <= '0;
            r_valid   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_v   <= n_cmp_v;
            r_arrival <= n_arrival;
            r_valid   <= n_valid;
            r_strobe  <= n_strobe;
        end
        r_order    <= n_order;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_cmp_idx  <= n_cmp_idx;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_ntrade   <= n_ntrade;
        r_result   <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;
endmodule

/* hw/rtl/lobm_checker.sv */
// Port-level checks on the order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_checker
    import lobm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_order  i_order,
    input logic    o_strobe,
    input t_result o_result
);
    // The final result of an order frees the block for the next transfer.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !busy)
        else $error("busy still high with final result");

    a_zero_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_order.order_quantity == '0)
        |=> o_strobe && o_result.last && (o_result.status == ST_ZERO))
        else $error("zero quantity order not closed at once");

    a_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_order.order_quantity != '0) |=> busy)
        else $error("order with quantity did not start matching");

    a_trade_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == ST_TRADE)
        |-> !o_result.last && (o_result.trade_quantity != '0))
        else $error("malformed trade result");

    a_final_no_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> (o_result.trade_quantity == '0))
        else $error("final result carries a trade quantity");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_order  (i_order),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
